### src/sks_pkg.sv
// Shared types, constants and helper functions of the hash-chain keystream block.
package sks_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_LOAD,
      ST_LDWAIT,
      ST_RUN,
      ST_EMIT,
      ST_CAPT
   } state_type;

   typedef struct packed {
      logic init;
      logic load;
      logic run;
   } core_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_sts_type;

   localparam int unsigned ROUNDS    = 80;
   localparam int unsigned PAD_BASE  = 144;    // 0x80 byte, 128-bit length, 127 for round-up
   localparam logic [63:0] CHAIN_PAD = 64'h8000_0000_0000_0000;
   localparam logic [63:0] CHAIN_LEN = 64'd384;

   localparam logic [63:0] IV384 [8] = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
   };

   localparam logic [63:0] RK [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [63:0] big_sig0(input logic [63:0] x);
      return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic logic [63:0] big_sig1(input logic [63:0] x);
      return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

   function automatic logic [63:0] sml_sig0(input logic [63:0] x);
      return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic logic [63:0] sml_sig1(input logic [63:0] x);
      return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

   function automatic logic [63:0] bswap(input logic [63:0] x);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) begin
         r[8*i +: 8] = x[8*(7-i) +: 8];
      end
      return r;
   endfunction

   // ones in the low n bytes
   function automatic logic [63:0] byte_mask(input logic [3:0] n);
      logic [63:0] m;
      for (int i = 0; i < 8; i++) begin
         m[8*i +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
      end
      return m;
   endfunction

endpackage

### src/sks_msg_store.sv
// Message store: byte packer in front of a word memory, with length and overflow tracking.
module sks_msg_store #(
   parameter int unsigned MAX_WORDS = 64,
   parameter int unsigned LW = $clog2(MAX_WORDS*8+1),
   parameter int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr,
   input  logic [63:0]   wr_word,
   input  logic [3:0]    wr_count,
   input  logic          flush,
   input  logic          clear,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data,
   output logic [LW-1:0] length,
   output logic          overflow
);

   localparam logic [LW-1:0] CAP = LW'(MAX_WORDS*8);

   logic [63:0]   mem [MAX_WORDS];
   logic [63:0]   rd_data_ff;
   logic [63:0]   acc_ff, acc_in;
   logic [LW-1:0] len_ff, len_in;
   logic          ovf_ff, ovf_in;

   logic [LW-1:0]  room;
   logic [3:0]     cnt8, take;
   logic           drop;
   logic [2:0]     k;
   logic [127:0]   comb;
   logic [4:0]     fill;
   logic           full;
   logic [AW-1:0]  widx;

   always_comb begin
      room   = CAP - len_ff;
      cnt8   = (wr_count > 4'd8) ? 4'd8 : wr_count;
      drop   = LW'(cnt8) > room;
      take   = drop ? room[3:0] : cnt8;
      k      = len_ff[2:0];
      comb   = {64'd0, acc_ff & sks_pkg::byte_mask({1'b0, k})}
             | ({64'd0, wr_word & sks_pkg::byte_mask(take)} << {k, 3'b000});
      fill   = {2'b00, k} + {1'b0, take};
      full   = fill >= 5'd8;
      widx   = len_ff[AW+2:3];
      len_in = len_ff;
      ovf_in = ovf_ff;
      acc_in = acc_ff;
      if (wr) begin
         len_in = len_ff + LW'(take);
         ovf_in = ovf_ff | drop;
         acc_in = full ? comb[127:64] : comb[63:0];
      end
      if (clear) begin
         len_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (wr && full) begin
         mem[widx] <= comb[63:0];
      end else if (flush && (k != 3'd0)) begin
         mem[widx] <= acc_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign length   = len_ff;
   assign overflow = ovf_ff;

   a_len_cap: assert property (@(posedge clock) disable iff (reset) len_ff <= CAP)
      else $error("stored length beyond capacity");

endmodule

### src/sks_sha_core.sv
// SHA-384 compression unit: rolling 16-word schedule, one round per cycle.
module sks_sha_core (
   input  logic                      clock,
   input  logic                      reset,
   input  sks_pkg::core_ctl_type     ctl,
   input  logic [63:0]               load_word,
   output sks_pkg::core_sts_type     sts,
   output logic [5:0][63:0]          digest
);

   logic [63:0] h_ff [8];
   logic [63:0] v_ff [8];
   logic [63:0] w_ff [16];
   logic [6:0]  rnd_ff;
   logic        busy_ff, add_ff, done_ff;

   logic [63:0] t1, t2, w_new;

   always_comb begin
      t1 = v_ff[7] + sks_pkg::big_sig1(v_ff[4])
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + sks_pkg::RK[rnd_ff] + w_ff[0];
      t2 = sks_pkg::big_sig0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      w_new = w_ff[0] + sks_pkg::sml_sig0(w_ff[1]) + w_ff[9] + sks_pkg::sml_sig1(w_ff[14]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         add_ff  <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff  <= '0;
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= sks_pkg::IV384[i];
         end
      end else begin
         done_ff <= 1'b0;
         if (ctl.init) begin
            for (int i = 0; i < 8; i++) begin
               h_ff[i] <= sks_pkg::IV384[i];
            end
         end
         if (ctl.run) begin
            busy_ff <= 1'b1;
            rnd_ff  <= '0;
         end else if (busy_ff) begin
            rnd_ff <= rnd_ff + 7'd1;
            if (rnd_ff == 7'(sks_pkg::ROUNDS - 1)) begin
               busy_ff <= 1'b0;
               add_ff  <= 1'b1;
            end
         end
         if (add_ff) begin
            for (int i = 0; i < 8; i++) begin
               h_ff[i] <= h_ff[i] + v_ff[i];
            end
            add_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= load_word;
      end else if (busy_ff) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= w_new;
      end
      if (ctl.run) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= h_ff[i];
         end
      end else if (busy_ff) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   always_comb begin
      sts.busy = busy_ff | add_ff;
      sts.done = done_ff;
      for (int i = 0; i < 6; i++) begin
         digest[i] = h_ff[i];
      end
   end

   a_run_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.run |-> !(busy_ff || add_ff))
      else $error("compression started while busy");

   a_done_after_add: assert property (@(posedge clock) disable iff (reset)
      add_ff |=> done_ff && !busy_ff)
      else $error("completion did not follow the final add");

endmodule

### src/sha384_chained_keystream_xor_top.sv
// Top level: message collection, SHA-384 chained keystream and XOR output sequencing.
//
//   channel | ports                                          | moves
//   req     | req_valid req_ready req_word req_count req_last | one message request word
//   rsp     | rsp_valid rsp_ready rsp_word rsp_count rsp_last | one XORed output word
//           | rsp_overflow                                   |
//
// A non-final request is taken while idle and the block stays idle. The final request starts the
// keystream: a flush step, then per 128-byte SHA block a schedule load of 16 words, a start step,
// 80 rounds on the single round unit, an add step and a completion step. Message hashing runs
// (len+144)/128 blocks; each further 48-byte key block is one more compression, taken after
// every sixth output word. Each output word takes a store read, then a capture, after any rsp
// stall. An empty message skips hashing and returns one zero word marked last.
// Reset is synchronous; no clearing pass is needed. Requests are taken only while idle.
module sha384_chained_keystream_xor_top #(
   parameter int unsigned MAX_WORDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_word,
   input  logic [3:0]  req_count,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_word,
   output logic [3:0]  rsp_count,
   output logic        rsp_last,
   output logic        rsp_overflow
);

   localparam int unsigned LW  = $clog2(MAX_WORDS*8+1);
   localparam int unsigned AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int unsigned NBM = (MAX_WORDS*8 + sks_pkg::PAD_BASE) / 128;
   localparam int unsigned BW  = $clog2(NBM+1);
   localparam int unsigned GW  = BW + 4;
   localparam int unsigned MW  = (GW > LW) ? GW : LW;
   localparam int unsigned CW  = ((MW > 8) ? MW : 8) + 1;
   localparam int unsigned OW  = LW - 2;

   sks_pkg::state_type     state_ff, state_in;
   sks_pkg::core_ctl_type  ctl;
   sks_pkg::core_sts_type  sts;
   logic [5:0][63:0]       digest;

   logic          req_acc;
   logic          st_flush, st_clear, rd_en;
   logic [AW-1:0] rd_addr;
   logic [GW-1:0] ld_addr;
   logic [63:0]   rd_data;
   logic [LW-1:0] len;
   logic          ovf;

   logic [3:0]    li_ff, ld_i_ff;
   logic          ld_v_ff;
   logic [BW-1:0] blk_ff;
   logic          chain_ff;
   logic [OW-1:0] ow_ff;
   logic [2:0]    kidx_ff;
   logic [63:0]   cd_ff [6];

   logic          rsp_valid_ff;
   logic [63:0]   rsp_word_ff;
   logic [3:0]    rsp_count_ff;
   logic          rsp_last_ff, rsp_overflow_ff;

   logic [CW-1:0] nblocks, fw, gwd;
   logic          last_blk;
   logic [63:0]   ld_word, part;
   logic [LW:0]   remain;
   logic [3:0]    ocount;
   logic          olast, rsp_free;

   assign req_acc  = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign ld_addr  = {blk_ff, li_ff};

   sks_msg_store #(.MAX_WORDS(MAX_WORDS), .LW(LW), .AW(AW)) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (req_acc),
      .wr_word  (req_word),
      .wr_count (req_count),
      .flush    (st_flush),
      .clear    (st_clear),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .length   (len),
      .overflow (ovf)
   );

   sks_sha_core u_core (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .load_word (ld_word),
      .sts       (sts),
      .digest    (digest)
   );

   // block word assembly: message words with padding, or the previous digest
   always_comb begin
      nblocks  = (CW'(len) + CW'(sks_pkg::PAD_BASE)) >> 7;
      last_blk = (CW'(blk_ff) + CW'(1)) == nblocks;
      fw       = CW'(len >> 3);
      gwd      = CW'({blk_ff, ld_i_ff});
      part     = (rd_data & sks_pkg::byte_mask({1'b0, len[2:0]}))
               | (64'h80 << {len[2:0], 3'b000});
      ld_word  = 64'd0;
      if (chain_ff) begin
         if (ld_i_ff < 4'd6) begin
            ld_word = cd_ff[ld_i_ff[2:0]];
         end else if (ld_i_ff == 4'd6) begin
            ld_word = sks_pkg::CHAIN_PAD;
         end else if (ld_i_ff == 4'd15) begin
            ld_word = sks_pkg::CHAIN_LEN;
         end
      end else if (gwd < fw) begin
         ld_word = sks_pkg::bswap(rd_data);
      end else if (gwd == fw) begin
         ld_word = sks_pkg::bswap(part);
      end else if (last_blk && (ld_i_ff == 4'd15)) begin
         ld_word = 64'({len, 3'b000});
      end
   end

   always_comb begin
      remain = (LW+1)'(len) - (LW+1)'({ow_ff, 3'b000});
      ocount = (remain >= (LW+1)'(8)) ? 4'd8 : remain[3:0];
      olast  = remain <= (LW+1)'(8);
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      ctl.load  = ld_v_ff;
      st_flush  = 1'b0;
      st_clear  = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = ow_ff[AW-1:0];
      req_ready = 1'b0;
      unique case (state_ff)
         sks_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_last) begin
               state_in = sks_pkg::ST_FLUSH;
            end
         end
         sks_pkg::ST_FLUSH: begin
            st_flush = 1'b1;
            ctl.init = 1'b1;
            state_in = (len == '0) ? sks_pkg::ST_EMIT : sks_pkg::ST_LOAD;
         end
         sks_pkg::ST_LOAD: begin
            rd_en   = 1'b1;
            rd_addr = ld_addr[AW-1:0];
            if (li_ff == 4'd15) begin
               state_in = sks_pkg::ST_LDWAIT;
            end
         end
         sks_pkg::ST_LDWAIT: begin
            ctl.run  = 1'b1;
            state_in = sks_pkg::ST_RUN;
         end
         sks_pkg::ST_RUN: begin
            if (sts.done) begin
               state_in = (!chain_ff && !last_blk) ? sks_pkg::ST_LOAD : sks_pkg::ST_EMIT;
            end
         end
         sks_pkg::ST_EMIT: begin
            if (rsp_free) begin
               if (len == '0) begin
                  st_clear = 1'b1;
                  state_in = sks_pkg::ST_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  state_in = sks_pkg::ST_CAPT;
               end
            end
         end
         sks_pkg::ST_CAPT: begin
            if (olast) begin
               st_clear = 1'b1;
               state_in = sks_pkg::ST_IDLE;
            end else if (kidx_ff == 3'd5) begin
               ctl.init = 1'b1;
               state_in = sks_pkg::ST_LOAD;
            end else begin
               state_in = sks_pkg::ST_EMIT;
            end
         end
         default: state_in = sks_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sks_pkg::ST_IDLE;
         li_ff        <= '0;
         ld_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ld_v_ff  <= (state_ff == sks_pkg::ST_LOAD);
         if (state_ff == sks_pkg::ST_LOAD) begin
            li_ff <= li_ff + 4'd1;
         end
         if (state_ff == sks_pkg::ST_CAPT
             || (state_ff == sks_pkg::ST_EMIT && rsp_free && len == '0)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ld_i_ff <= li_ff;
      if (state_ff == sks_pkg::ST_FLUSH) begin
         blk_ff   <= '0;
         chain_ff <= 1'b0;
         ow_ff    <= '0;
         kidx_ff  <= '0;
      end
      if (state_ff == sks_pkg::ST_RUN && sts.done) begin
         if (state_in == sks_pkg::ST_LOAD) begin
            blk_ff <= blk_ff + BW'(1);
         end else begin
            for (int i = 0; i < 6; i++) begin
               cd_ff[i] <= digest[i];
            end
         end
      end
      if (state_ff == sks_pkg::ST_EMIT && rsp_free && len == '0) begin
         rsp_word_ff     <= 64'd0;
         rsp_count_ff    <= 4'd0;
         rsp_last_ff     <= 1'b1;
         rsp_overflow_ff <= 1'b0;
      end
      if (state_ff == sks_pkg::ST_CAPT) begin
         rsp_word_ff     <= (rd_data ^ sks_pkg::bswap(cd_ff[kidx_ff]))
                          & sks_pkg::byte_mask(ocount);
         rsp_count_ff    <= ocount;
         rsp_last_ff     <= olast;
         rsp_overflow_ff <= ovf;
         ow_ff           <= ow_ff + OW'(1);
         kidx_ff         <= (kidx_ff == 3'd5) ? 3'd0 : kidx_ff + 3'd1;
         if (kidx_ff == 3'd5) begin
            chain_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word     = rsp_word_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_overflow = rsp_overflow_ff;

   a_capt_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == sks_pkg::ST_CAPT |-> !rsp_valid_ff)
      else $error("output word captured over an untaken one");

   a_run_after_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == sks_pkg::ST_LDWAIT |-> ld_v_ff && ld_i_ff == 4'd15)
      else $error("compression started on a partial block");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && rsp_last_ff |-> state_ff != sks_pkg::ST_CAPT)
      else $error("capture overlapped the final word");

endmodule

### verif/sha384_chained_keystream_xor_top_tb.sv
// Testbench for the SHA-384 chained keystream XOR block: own hash predictor, random traffic.
`timescale 1ns / 100ps

class keystream_scoreboard;
   localparam int CAP = 512;
   logic [63:0] iv [8];
   logic [63:0] kc [80];
   logic [7:0]  msg_bytes [CAP];
   int unsigned msg_len;
   bit          dropped;
   logic [63:0] exp_word [$];
   logic [3:0]  exp_count [$];
   logic        exp_last [$];
   logic        exp_ovf [$];
   int          errors;

   function new();
      iv = sks_pkg::IV384;
      kc = sks_pkg::RK;
      msg_len = 0;
      dropped = 0;
      errors = 0;
   endfunction

   function logic [63:0] ror(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function void compress(ref logic [63:0] h [8], input logic [63:0] blk [16]);
      logic [63:0] w [80];
      logic [63:0] a, b, c, d, e, f, g, hh, t1, t2;
      for (int t = 0; t < 16; t++) w[t] = blk[t];
      for (int t = 16; t < 80; t++)
         w[t] = w[t-16] + (ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-7]
              + (ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6));
      a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; hh = h[7];
      for (int t = 0; t < 80; t++) begin
         t1 = hh + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41)) + ((e & f) ^ (~e & g)) + kc[t] + w[t];
         t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
         hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d;
      h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
   endfunction

   // digest of len bytes of data into 48 bytes
   function void digest(input logic [7:0] data [CAP], input int unsigned len,
                        output logic [7:0] dig [48]);
      logic [63:0] h [8];
      logic [63:0] blk [16];
      int unsigned nb, total, p;
      logic [63:0] bits;
      logic [7:0] by;
      h = iv;
      nb = (len + 17 + 127) / 128;
      total = nb * 128;
      bits = 64'(len) * 8;
      for (int b = 0; b < nb; b++) begin
         for (int i = 0; i < 16; i++) blk[i] = '0;
         for (int i = 0; i < 128; i++) begin
            p = b * 128 + i;
            by = 8'h00;
            if (p < len) by = data[p];
            else if (p == len) by = 8'h80;
            else if (p >= total - 8) by = 8'(bits >> (8 * (total - 1 - p)));
            blk[i/8][8*(7-i%8) +: 8] = by;
         end
         compress(h, blk);
      end
      for (int i = 0; i < 48; i++) dig[i] = h[i/8][8*(7-i%8) +: 8];
   endfunction

   function void note_request(logic [63:0] word, logic [3:0] count, logic last);
      logic [7:0] ks [CAP+48];
      logic [7:0] dig [48];
      logic [7:0] prev [CAP];
      int unsigned n, nwords, nb;
      logic [63:0] v;
      n = (count > 8) ? 8 : count;
      for (int i = 0; i < n; i++) begin
         if (msg_len < CAP) begin
            msg_bytes[msg_len] = word[8*i +: 8];
            msg_len++;
         end else dropped = 1;
      end
      if (!last) return;
      digest(msg_bytes, msg_len, dig);
      for (int i = 0; i < 48; i++) ks[i] = dig[i];
      nb = msg_len / 48 + 1;
      for (int k = 1; k < nb; k++) begin
         for (int i = 0; i < 48; i++) prev[i] = ks[(k-1)*48 + i];
         digest(prev, 48, dig);
         for (int i = 0; i < 48; i++) ks[k*48 + i] = dig[i];
      end
      nwords = (msg_len + 7) / 8;
      if (nwords == 0) begin
         exp_word.push_back('0); exp_count.push_back('0);
         exp_last.push_back(1'b1); exp_ovf.push_back(1'b0);
      end
      for (int w = 0; w < nwords; w++) begin
         n = msg_len - w * 8;
         if (n > 8) n = 8;
         v = '0;
         for (int i = 0; i < n; i++) v[8*i +: 8] = msg_bytes[w*8+i] ^ ks[w*8+i];
         exp_word.push_back(v); exp_count.push_back(4'(n));
         exp_last.push_back(w + 1 == nwords); exp_ovf.push_back(dropped);
      end
      msg_len = 0;
      dropped = 0;
   endfunction

   function void check_result(logic [63:0] word, logic [3:0] count, logic last, logic ovf);
      logic [63:0] ew;
      logic [3:0] ec;
      logic el, eo;
      if (exp_word.size() == 0) begin
         $display("%0t: unexpected response word %h", $time, word);
         errors++;
         return;
      end
      ew = exp_word.pop_front(); ec = exp_count.pop_front();
      el = exp_last.pop_front(); eo = exp_ovf.pop_front();
      if (word !== ew) begin
         $display("%0t: word expected %h actual %h", $time, ew, word); errors++;
      end
      if (count !== ec) begin
         $display("%0t: count expected %0d actual %0d", $time, ec, count); errors++;
      end
      if (last !== el) begin
         $display("%0t: last expected %b actual %b", $time, el, last); errors++;
      end
      if (ovf !== eo) begin
         $display("%0t: overflow expected %b actual %b", $time, eo, ovf); errors++;
      end
   endfunction

   function int pending();
      return exp_word.size();
   endfunction
endclass

module sha384_chained_keystream_xor_top_tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [63:0] req_word = '0;
   logic [3:0]  req_count = 4'd1;
   logic        req_last = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [63:0] rsp_word;
   logic [3:0]  rsp_count;
   logic        rsp_last;
   logic        rsp_overflow;

   keystream_scoreboard sb = new();
   bit   hold_off = 0;
   int   quiet_cycles = 0;
   int   n_sent = 0;

   sha384_chained_keystream_xor_top u_top (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   function automatic int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
   endfunction

   // valid stays high into the next request when there is no gap
   task automatic send_request(logic [63:0] word, logic [3:0] count, logic last);
      int g;
      g = gap_length();
      if ($urandom_range(0, 3) == 0) g = 0;
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1; req_word <= word; req_count <= count; req_last <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_request(word, count, last);
      n_sent++;
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // whole message of nbytes, split into random word sizes
   task automatic send_message(int nbytes);
      int c;
      while (nbytes > 8 || (nbytes > 0 && $urandom_range(0, 1))) begin
         c = $urandom_range(1, 8);
         if (c > nbytes) c = nbytes;
         nbytes -= c;
         send_request(rand_word(), 4'(c), nbytes == 0);
         if (nbytes == 0) return;
      end
      send_request(rand_word(), 4'(nbytes), 1'b1);
   endtask

   // response side
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_word, rsp_count, rsp_last, rsp_overflow);
         if (hold_off) rsp_ready <= 0;
         else rsp_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
      end
   end

   // long receiver stall while requests keep coming
   initial begin
      int cnt;
      wait (!reset);
      repeat (3000) @(posedge clock);
      hold_off = 1;
      cnt = 0;
      while (cnt < 600) begin
         @(posedge clock);
         cnt++;
      end
      hold_off = 0;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_off) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("FAIL sha384_chained_keystream_xor_top");
         $finish;
      end
   end

   initial begin
      int n;
      repeat (12) @(posedge clock);
      reset <= 0;
      // directed: empty, zero count, over-eight count, extremes, boundary lengths
      send_request('0, 4'd0, 1'b1);
      send_request(64'hffff_ffff_ffff_ffff, 4'd8, 1'b0);
      send_request('0, 4'd0, 1'b0);
      send_request(64'h0123_4567_89ab_cdef, 4'd15, 1'b1);
      send_request(64'hffff_ffff_ffff_ffff, 4'd1, 1'b1);
      send_request('0, 4'd8, 1'b0);
      send_request(64'h8000_0000_0000_0001, 4'd9, 1'b1);
      send_message(47);
      send_message(48);
      send_message(111);
      send_message(112);
      // overflow: 66 full words
      for (int i = 0; i < 66; i++) send_request(rand_word(), 4'd8, i == 65);
      send_message(512);
      while (n_sent < 450) begin
         if ($urandom_range(0, 19) == 0)
            send_request(rand_word(), 4'($urandom_range(0, 15)), $urandom_range(0, 1));
         else begin
            n = ($urandom_range(0, 14) == 0) ? $urandom_range(200, 530) : $urandom_range(0, 60);
            send_message(n);
         end
      end
      req_valid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.errors == 0) $display("PASS sha384_chained_keystream_xor_top");
      else $display("FAIL sha384_chained_keystream_xor_top");
      $finish;
   end
endmodule

### sim.f
src/sks_pkg.sv
src/sks_msg_store.sv
src/sks_sha_core.sv
src/sha384_chained_keystream_xor_top.sv
verif/sha384_chained_keystream_xor_top_tb.sv
